@@ rtl/utf8_emoji_classifier_defines.svh @@
// Assertion macros for the UTF-8 emoji classifier checker.
// Used only by the checker file; no other dependencies.
`ifndef UTF8_EMOJI_CLASSIFIER_DEFINES_SVH
`define UTF8_EMOJI_CLASSIFIER_DEFINES_SVH

// Concurrent assertion sampled on clk, inactive while reset is held.
`define UTF8E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk that also checks across reset.
`define UTF8E_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/utf8e_pkg.sv @@
// Shared types, constants and functions of the UTF-8 emoji classifier.
// No dependencies; used by all RTL modules.
package utf8e_pkg;

  localparam int CP_W        = 31;
  localparam int CNT_W       = 3;
  localparam int FIFO_DEPTH  = 4;

  // One decoded character as it travels from the decoder to the output stage.
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             bad_sequence;
  } char_t;

  // Status of the queue between decoder and output stage.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CNT_W-1:0] head_len(input logic [7:0] b);
    logic [CNT_W-1:0] len;
    if (b < 8'hC0)      len = 3'd1;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else                len = 3'd6;
    return len;
  endfunction

  // Payload bits of a multi-byte head byte: 7 - len of them.
  function automatic logic [CP_W-1:0] head_payload(input logic [7:0] b,
                                                    input logic [CNT_W-1:0] len);
    logic [CP_W-1:0] v;
    case (len)
      3'd2:    v = {26'd0, b[4:0]};
      3'd3:    v = {27'd0, b[3:0]};
      3'd4:    v = {28'd0, b[2:0]};
      3'd5:    v = {29'd0, b[1:0]};
      3'd6:    v = {30'd0, b[0]};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic in_rng(input logic [CP_W-1:0] v,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic emoji_class(input logic [CP_W-1:0] v);
    logic hit;
    hit = in_rng(v, 31'h1F680, 31'h1F6A4) || in_rng(v, 31'h1F300, 31'h1F320) ||
          in_rng(v, 31'h1F330, 31'h1F335) || in_rng(v, 31'h1F337, 31'h1F37C) ||
          in_rng(v, 31'h1F380, 31'h1F393) || in_rng(v, 31'h1F3A0, 31'h1F3C4) ||
          in_rng(v, 31'h1F3C6, 31'h1F3CA) || in_rng(v, 31'h1F3E0, 31'h1F3F0) ||
          in_rng(v, 31'h1F500, 31'h1F53D) || in_rng(v, 31'h1F540, 31'h1F543) ||
          in_rng(v, 31'h1F550, 31'h1F567) || in_rng(v, 31'h1F5FB, 31'h1F5FF) ||
          in_rng(v, 31'h1F6A5, 31'h1F6C5) ||
          (in_rng(v, 31'h1F400, 31'h1F4FC) && (v != 31'h1F441) &&
           (v != 31'h1F43F) && (v != 31'h1F4F8)) ||
          in_rng(v, 31'h1F641, 31'h1F644);
    return hit;
  endfunction

endpackage

@@ rtl/utf8e_front.sv @@
// Decoder front end: accepts bytes and assembles UTF-8 characters.
// Depends on utf8e_pkg; writes finished characters into utf8e_fifo.
module utf8e_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [7:0]            in_data_byte,
  input  utf8e_pkg::q_stat_t    q_stat,
  output logic                  wr_en,
  output utf8e_pkg::char_t      wr_data
);

  logic [utf8e_pkg::CNT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [utf8e_pkg::CNT_W-1:0] seq_length_r, seq_length_nxt;
  logic [utf8e_pkg::CP_W-1:0]  partial_r, partial_nxt;
  logic [utf8e_pkg::CNT_W-1:0] len;
  logic                        accept;

  assign accept = in_push && !q_stat.full;
  assign len    = utf8e_pkg::head_len(in_data_byte);

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_length_nxt = seq_length_r;
    partial_nxt    = partial_r;
    wr_en          = 1'b0;
    wr_data        = '0;
    if (accept) begin
      if (bytes_left_r == '0) begin
        if (len == 3'd1) begin
          wr_en              = 1'b1;
          wr_data.code_point = {23'd0, in_data_byte};
          wr_data.byte_count = 3'd1;
        end else begin
          partial_nxt    = utf8e_pkg::head_payload(in_data_byte, len);
          seq_length_nxt = len;
          bytes_left_nxt = len - 3'd1;
        end
      end else if (in_data_byte[7:6] != 2'b10) begin
        // Malformed continuation: drop the partial character.
        wr_en                = 1'b1;
        wr_data.bad_sequence = 1'b1;
        bytes_left_nxt       = '0;
        seq_length_nxt       = '0;
        partial_nxt          = '0;
      end else begin
        partial_nxt    = {partial_r[utf8e_pkg::CP_W-7:0], in_data_byte[5:0]};
        bytes_left_nxt = bytes_left_r - 3'd1;
        if (bytes_left_r == 3'd1) begin
          wr_en              = 1'b1;
          wr_data.code_point = partial_nxt;
          wr_data.byte_count = seq_length_r;
          seq_length_nxt     = '0;
          partial_nxt        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_length_r <= '0;
      partial_r    <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      seq_length_r <= seq_length_nxt;
      partial_r    <= partial_nxt;
    end
  end

endmodule

@@ rtl/utf8e_fifo.sv @@
// Short queue of decoded characters between decoder and output stage.
// Depends on utf8e_pkg for the entry and status types.
module utf8e_fifo #(
  parameter int DEPTH = utf8e_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  utf8e_pkg::char_t   wr_data,
  input  logic               rd_en,
  output utf8e_pkg::char_t   rd_data,
  output utf8e_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8e_pkg::char_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_wr, do_rd;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_wr   = wr_en && !q_stat.full;
  assign do_rd   = rd_en && !q_stat.empty;
  assign rd_data = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= bump(wr_ptr_r);
      if (do_rd) rd_ptr_r <= bump(rd_ptr_r);
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

@@ rtl/utf8e_back.sv @@
// Output stage: classifies each character and holds it for the receiver.
// Depends on utf8e_pkg; reads characters from utf8e_fifo.
module utf8e_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  utf8e_pkg::q_stat_t            q_stat,
  input  utf8e_pkg::char_t              rd_data,
  output logic                          rd_en,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [utf8e_pkg::CP_W-1:0]    out_code_point,
  output logic [utf8e_pkg::CNT_W-1:0]   out_byte_count,
  output logic                          out_is_emoji,
  output logic                          out_bad_sequence
);

  logic                        valid_r;
  logic [utf8e_pkg::CP_W-1:0]  cp_r;
  logic [utf8e_pkg::CNT_W-1:0] cnt_r;
  logic                        emoji_r;
  logic                        bad_r;

  // Refill the output register whenever it is free or being drained.
  assign rd_en = !q_stat.empty && (!valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rd_en) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cp_r    <= rd_data.code_point;
      cnt_r   <= rd_data.byte_count;
      bad_r   <= rd_data.bad_sequence;
      emoji_r <= !rd_data.bad_sequence && utf8e_pkg::emoji_class(rd_data.code_point);
    end
  end

  assign out_empty        = !valid_r;
  assign out_code_point   = cp_r;
  assign out_byte_count   = cnt_r;
  assign out_is_emoji     = emoji_r;
  assign out_bad_sequence = bad_r;

endmodule

@@ rtl/utf8_emoji_classifier.sv @@
// UTF-8 decoder with emoji classification: top level.
// Instantiates utf8e_front, utf8e_fifo and utf8e_back; uses utf8e_pkg.
//
// Input channel: one byte per transfer on in_data_byte, taken when in_push
// is high and in_full is low. Result channel: the oldest decoded character
// is on the out_ ports while out_empty is low and leaves on out_pop.
// Head bytes of multi-byte characters and all but the last continuation
// byte give no result; the last byte, a one-byte character or a malformed
// continuation gives exactly one.
// Throughput: one byte per cycle unless in_full. The decoder takes a byte every
// cycle while the character queue has room; the output register reloads
// in the same cycle that its result is popped.
// A completed character reaches the out_ ports through a queue write and then
// an output register load; a result held on the out_ ports delays the load.
// When the receiver stalls, results collect in the FIFO_DEPTH-entry queue
// plus the output register; in_full rises once the queue is full.
// Reset (rst_n low, synchronous) clears the partial character, empties the
// queue and the output register; no clearing pass is needed.
module utf8_emoji_classifier #(
  parameter int FIFO_DEPTH = utf8e_pkg::FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [utf8e_pkg::CP_W-1:0]    out_code_point,
  output logic [utf8e_pkg::CNT_W-1:0]   out_byte_count,
  output logic                          out_is_emoji,
  output logic                          out_bad_sequence
);

  utf8e_pkg::q_stat_t q_stat;
  utf8e_pkg::char_t   wr_data, rd_data;
  logic               wr_en, rd_en;

  assign in_full = q_stat.full;

  utf8e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .q_stat       (q_stat),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  utf8e_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .q_stat  (q_stat)
  );

  utf8e_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .rd_data          (rd_data),
    .rd_en            (rd_en),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_code_point   (out_code_point),
    .out_byte_count   (out_byte_count),
    .out_is_emoji     (out_is_emoji),
    .out_bad_sequence (out_bad_sequence)
  );

endmodule

@@ rtl/utf8e_checker.sv @@
// Port-level checker for the UTF-8 emoji classifier, bound to the top level.
// Depends on utf8_emoji_classifier_defines.svh and utf8e_pkg.
`include "utf8_emoji_classifier_defines.svh"

module utf8e_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_push,
  input logic                          in_full,
  input logic [7:0]                    in_data_byte,
  input logic                          out_pop,
  input logic                          out_empty,
  input logic [utf8e_pkg::CP_W-1:0]    out_code_point,
  input logic [utf8e_pkg::CNT_W-1:0]   out_byte_count,
  input logic                          out_is_emoji,
  input logic                          out_bad_sequence
);

  `UTF8E_ASSERT(a_hold_result, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_code_point)), "stalled result changed")
  `UTF8E_ASSERT(a_bad_fields, (!out_empty && out_bad_sequence) |-> (out_code_point == '0 && out_byte_count == '0 && !out_is_emoji), "error result carries data")
  `UTF8E_ASSERT(a_good_count, (!out_empty && !out_bad_sequence) |-> (out_byte_count != '0 && out_byte_count <= 3'd6), "byte count out of range")
  `UTF8E_ASSERT(a_single_byte, (!out_empty && out_byte_count == 3'd1) |-> (out_code_point <= 31'hFF && !out_is_emoji), "one-byte character too large")
  `UTF8E_ASSERT_RST(a_reset_clear, !rst_n |=> (out_empty && !in_full), "reset did not clear the block")

endmodule

bind utf8_emoji_classifier utf8e_checker u_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the UTF-8 decoder with emoji classification.
// Depends on utf8e_pkg and utf8_emoji_classifier; drives bytes in bursts and
// checks every decoded character against an in-bench decoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CP_W  = utf8e_pkg::CP_W;
  localparam int CNT_W = utf8e_pkg::CNT_W;
  localparam int NUM_RANGES = 17;
  localparam int RANDOM_BYTES = 1450;

  // Emoji ranges as {low, high}; the excluded points split the 0x1F4xx block.
  localparam logic [NUM_RANGES-1:0][2*CP_W-1:0] EMOJI_RANGES = {
    {31'h1F300, 31'h1F320}, {31'h1F330, 31'h1F335}, {31'h1F337, 31'h1F37C},
    {31'h1F380, 31'h1F393}, {31'h1F3A0, 31'h1F3C4}, {31'h1F3C6, 31'h1F3CA},
    {31'h1F3E0, 31'h1F3F0}, {31'h1F400, 31'h1F43E}, {31'h1F440, 31'h1F440},
    {31'h1F442, 31'h1F4F7}, {31'h1F4F9, 31'h1F4FC}, {31'h1F500, 31'h1F53D},
    {31'h1F540, 31'h1F543}, {31'h1F550, 31'h1F567}, {31'h1F5FB, 31'h1F5FF},
    {31'h1F641, 31'h1F644}, {31'h1F680, 31'h1F6C5}
  };

  typedef struct {
    logic [7:0] value;
    bit         pause;
  } text_item_t;

  typedef struct {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             is_emoji;
    logic             bad_sequence;
  } char_t;

  logic             clk;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [7:0]       in_data_byte;
  logic             out_pop;
  logic             out_empty;
  logic [CP_W-1:0]  out_code_point;
  logic [CNT_W-1:0] out_byte_count;
  logic             out_is_emoji;
  logic             out_bad_sequence;

  text_item_t text_bytes[$];
  char_t      pending_chars[$];
  int         err_count;

  // Decoder state of the prediction.
  logic [2:0]      dec_left;
  logic [2:0]      dec_len;
  logic [CP_W-1:0] dec_partial;

  // Sender and receiver pacing.
  int burst_left;
  int gap_left;
  bit offer;
  int chars_seen;
  int hold_left;
  int window_left;
  int pop_mode;
  bit pop_next;

  utf8_emoji_classifier u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_code_point   (out_code_point),
    .out_byte_count   (out_byte_count),
    .out_is_emoji     (out_is_emoji),
    .out_bad_sequence (out_bad_sequence)
  );

  function automatic bit emoji_point(input logic [CP_W-1:0] v);
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (v >= EMOJI_RANGES[i][2*CP_W-1:CP_W] && v <= EMOJI_RANGES[i][CP_W-1:0]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic queue_char(input logic [CP_W-1:0] cp, input logic [CNT_W-1:0] count,
                            input logic bad);
    char_t c;
    c.code_point   = cp;
    c.byte_count   = count;
    c.is_emoji     = !bad && emoji_point(cp);
    c.bad_sequence = bad;
    pending_chars.push_back(c);
  endtask

  // Advances the decoder by one accepted byte and records any character or error result it completes.
  task automatic decode_byte(input logic [7:0] b);
    logic [2:0] len;
    if (dec_left == 3'd0) begin
      if (b < 8'hC0) begin
        queue_char({23'd0, b}, 3'd1, 1'b0);
      end else begin
        if (b < 8'hE0)      len = 3'd2;
        else if (b < 8'hF0) len = 3'd3;
        else if (b < 8'hF8) len = 3'd4;
        else if (b < 8'hFC) len = 3'd5;
        else                len = 3'd6;
        dec_partial = CP_W'(b) & ((31'd1 << (7 - len)) - 31'd1);
        dec_len     = len;
        dec_left    = len - 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      dec_left    = 3'd0;
      dec_len     = 3'd0;
      dec_partial = '0;
      queue_char('0, 3'd0, 1'b1);
    end else begin
      dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
      dec_left    = dec_left - 3'd1;
      if (dec_left == 3'd0) begin
        queue_char(dec_partial, dec_len, 1'b0);
        dec_len     = 3'd0;
        dec_partial = '0;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_bytes.push_back('{value: b, pause: 1'b0});
  endtask

  // The sender stops at this mark until every expected character has come out.
  task automatic add_pause();
    text_bytes.push_back('{value: 8'h00, pause: 1'b1});
  endtask

  function automatic logic [7:0] lead_byte(input int len, input logic [CP_W-1:0] cp);
    logic [7:0] prefix;
    prefix = 8'hFF << (8 - len);
    return prefix | 8'((cp >> (6 * (len - 1))) & ((31'd1 << (7 - len)) - 31'd1));
  endfunction

  task automatic add_char(input int len, input logic [CP_W-1:0] cp);
    if (len == 1) begin
      add_byte(cp[7:0]);
    end else begin
      add_byte(lead_byte(len, cp));
      for (int k = len - 2; k >= 0; k--) begin
        add_byte(8'h80 | 8'((cp >> (6 * k)) & 31'h3F));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Driver: offers queued bytes in bursts, holds an offer until it transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push      <= 1'b0;
      in_data_byte <= 8'h00;
      burst_left   = 1;
      gap_left     = 0;
      dec_left     = 3'd0;
      dec_len      = 3'd0;
      dec_partial  = '0;
    end else begin
      if (in_push && !in_full) begin
        decode_byte(in_data_byte);
        text_bytes.delete(0);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (!(in_push && in_full)) begin
        offer = 1'b0;
        if (text_bytes.size() > 0 && text_bytes[0].pause) begin
          if (pending_chars.size() == 0) begin
            text_bytes.delete(0);
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (text_bytes.size() > 0) begin
          offer = 1'b1;
        end
        in_push <= offer;
        if (offer) begin
          in_data_byte <= text_bytes[0].value;
        end
      end
    end
  end

  // Monitor: checks each transfer and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop     <= 1'b0;
      chars_seen  = 0;
      hold_left   = 0;
      window_left = 0;
      pop_mode    = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected result cp=%h count=%0d emoji=%b bad=%b", $time,
                   out_code_point, out_byte_count, out_is_emoji, out_bad_sequence);
          err_count++;
        end else begin
          if (out_code_point !== pending_chars[0].code_point ||
              out_byte_count !== pending_chars[0].byte_count ||
              out_is_emoji !== pending_chars[0].is_emoji ||
              out_bad_sequence !== pending_chars[0].bad_sequence) begin
            $display("%0t: mismatch expected cp=%h count=%0d emoji=%b bad=%b, actual cp=%h count=%0d emoji=%b bad=%b",
                     $time, pending_chars[0].code_point, pending_chars[0].byte_count,
                     pending_chars[0].is_emoji, pending_chars[0].bad_sequence,
                     out_code_point, out_byte_count, out_is_emoji, out_bad_sequence);
            err_count++;
          end
          pending_chars.delete(0);
        end
        chars_seen++;
        // Two long holds let the queue fill up and push back on the sender.
        if (chars_seen == 100 || chars_seen == 350) begin
          hold_left = 80;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else begin
        if (window_left == 0) begin
          pop_mode    = $urandom_range(0, 3);
          window_left = $urandom_range(5, 40);
        end else begin
          window_left--;
        end
        case (pop_mode)
          0:       pop_next = 1'b1;
          1:       pop_next = $urandom_range(0, 1);
          2:       pop_next = ($urandom_range(0, 3) == 0);
          default: pop_next = ($urandom_range(0, 7) != 0);
        endcase
      end
      out_pop <= pop_next;
    end
  end

  initial begin
    int          pick;
    int          len;
    int          n_good;
    int          bits;
    int          idx;
    logic [CP_W-1:0] cp;
    logic [7:0]  bad;
    bit          paused_once;
    bit          paused_twice;

    err_count    = 0;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data_byte = 8'h00;
    out_pop      = 1'b0;
    paused_once  = 1'b0;
    paused_twice = 1'b0;

    // Directed: single bytes including stray continuations, the smallest two-byte value,
    // the largest three-, five- and six-byte values, a four-byte emoji, and a malformed continuation.
    add_byte(8'h00);
    add_byte(8'h80);
    add_byte(8'hBF);
    add_char(2, 31'h0);
    add_char(3, 31'hFFFF);
    add_char(4, 31'h1F641);
    add_char(5, 31'h3FFFFFF);
    add_char(6, 31'h7FFFFFFF);
    add_byte(8'hE2);
    add_byte(8'h41);
    add_pause();

    while (text_bytes.size() < RANDOM_BYTES + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        add_byte(8'($urandom_range(0, 8'hBF)));
      end else if (pick < 55) begin
        if ($urandom_range(0, 1) == 0) begin
          idx = $urandom_range(0, NUM_RANGES - 1);
          case ($urandom_range(0, 3))
            0:       cp = EMOJI_RANGES[idx][2*CP_W-1:CP_W] - 31'd1;
            1:       cp = EMOJI_RANGES[idx][2*CP_W-1:CP_W];
            2:       cp = EMOJI_RANGES[idx][CP_W-1:0];
            default: cp = EMOJI_RANGES[idx][CP_W-1:0] + 31'd1;
          endcase
        end else begin
          cp = 31'h1F300 + CP_W'($urandom_range(0, 31'h3FF));
        end
        add_char(4, cp);
      end else if (pick < 75) begin
        len  = $urandom_range(2, 6);
        bits = 5 * len + 1;
        cp   = CP_W'($urandom & ((32'd1 << bits) - 32'd1));
        add_char(len, cp);
      end else if (pick < 85) begin
        // Broken sequence: a head, some good continuations, then a bad byte.
        len    = $urandom_range(2, 6);
        n_good = $urandom_range(0, len - 2);
        add_byte(lead_byte(len, CP_W'($urandom)));
        for (int k = 0; k < n_good; k++) begin
          add_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
        bad = 8'($urandom_range(0, 191));
        if (bad >= 8'h80) bad = bad + 8'h40;
        add_byte(bad);
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
      if (!paused_once && text_bytes.size() > 500) begin
        add_pause();
        paused_once = 1'b1;
      end
      if (!paused_twice && text_bytes.size() > 1000) begin
        add_pause();
        paused_twice = 1'b1;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (text_bytes.size() != 0 || pending_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
